FILE: src/opfp_pkg.sv
// Shared types and constants for the optical flow frame parser.
// No dependencies; used by optical_flow_frame_parser.
`timescale 1ns / 1ps
package opfp_pkg;

	localparam logic [7:0] HEADER_BYTE   = 8'hAA;
	localparam logic [7:0] SOURCE_RESET  = 8'h22;
	localparam logic [7:0] FUNC_FLOW     = 8'h51;
	localparam logic [7:0] FUNC_ALT      = 8'h52;
	localparam logic [7:0] MODE_FLOW     = 8'h01;
	localparam logic [7:0] MODE_ALT      = 8'h00;

	localparam logic KIND_FLOW = 1'b0;
	localparam logic KIND_ALT  = 1'b1;

	// Highest decoded frame position is 19; later bytes are never read back.
	localparam int STORE_DEPTH = 20;
	localparam int POS_W       = 9;

	localparam logic [POS_W-1:0] POS_HEADER  = 9'd0;
	localparam logic [POS_W-1:0] POS_SOURCE  = 9'd1;
	localparam logic [POS_W-1:0] POS_DEST    = 9'd2;
	localparam logic [POS_W-1:0] POS_FUNC    = 9'd3;
	localparam logic [POS_W-1:0] POS_LEN     = 9'd4;
	localparam logic [POS_W-1:0] POS_PAYLOAD = 9'd5;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_HEADER,
		PH_SOURCE,
		PH_DEST,
		PH_FUNC,
		PH_PAYLOAD,
		PH_CSUM
	} phase_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  quality;
		logic [15:0] speed_x;
		logic [15:0] speed_y;
		logic [15:0] speed_x_fixed;
		logic [15:0] speed_y_fixed;
		logic [15:0] dist_x;
		logic [15:0] dist_y;
		logic [7:0]  light;
		logic [15:0] altitude;
	} result_t;

endpackage

FILE: src/optical_flow_frame_parser.sv
// Top level of the optical flow frame parser: byte deframer, checksum,
// decode of flow and altitude frames, two-word result queue. Uses opfp_pkg.
`timescale 1ns / 1ps
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received serial
//   byte per word. Frames are 0xAA, source, destination, function, length,
//   payload and an 8-bit sum checksum over all earlier bytes.
//   Output channel (out_valid/out_ready) gives one word per good flow frame
//   (function 0x51, mode 1) or altitude frame (function 0x52, mode 0),
//   carrying every held value after the update.
//   cfg_we/cfg_wdata writes the expected source byte; write only when idle.
//   Throughput: one byte per cycle while in_ready is high; all parsing and
//   decode happen in the cycle a byte is accepted, set by the phase register
//   and sum adder. A result is presented the cycle after its checksum byte.
//   Results go into a two-word queue; in_ready drops only while both words
//   are waiting, so a stalled receiver holds off input after two results.
//   Reset: parser idle, held values and frame store zero, expected source
//   0x22, queue empty.
module optical_flow_frame_parser (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         rx_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               update_kind,
	output logic [7:0]         quality,
	output logic signed [15:0] speed_x,
	output logic signed [15:0] speed_y,
	output logic signed [15:0] speed_x_fixed,
	output logic signed [15:0] speed_y_fixed,
	output logic signed [15:0] dist_x,
	output logic signed [15:0] dist_y,
	output logic [7:0]         light,
	output logic [15:0]        altitude
);

	opfp_pkg::phase_t phase_q, phase_d;
	logic [7:0] source_q;
	logic [7:0] bytes_left_q, bytes_left_d;
	logic [7:0] payload_count_q, payload_count_d;
	logic [7:0] sum_q, sum_d;
	logic [7:0] store_q [opfp_pkg::STORE_DEPTH];
	logic [7:0] view [opfp_pkg::STORE_DEPTH];
	opfp_pkg::result_t held_q, result_d;

	logic                      in_fire, push, pop;
	logic                      wr_en, csum_ok, is_flow, is_alt;
	logic [opfp_pkg::POS_W-1:0] wr_pos, payload_pos;

	opfp_pkg::result_t slot_q [2];
	logic              wr_ptr_q, rd_ptr_q;
	logic [1:0]        count_q;

	assign in_fire     = in_valid && in_ready;
	assign payload_pos = opfp_pkg::POS_PAYLOAD + {1'b0, payload_count_q};

	// parser next state
	always_comb begin
		phase_d         = phase_q;
		bytes_left_d    = bytes_left_q;
		payload_count_d = payload_count_q;
		sum_d           = sum_q;
		wr_en           = 1'b0;
		wr_pos          = opfp_pkg::POS_HEADER;
		csum_ok         = 1'b0;
		case (phase_q)
			opfp_pkg::PH_IDLE: begin
				if (rx_byte == opfp_pkg::HEADER_BYTE) begin
					wr_en   = 1'b1;
					wr_pos  = opfp_pkg::POS_HEADER;
					sum_d   = rx_byte;
					phase_d = opfp_pkg::PH_HEADER;
				end
			end
			opfp_pkg::PH_HEADER: begin
				if (rx_byte == source_q) begin
					wr_en   = 1'b1;
					wr_pos  = opfp_pkg::POS_SOURCE;
					sum_d   = sum_q + rx_byte;
					phase_d = opfp_pkg::PH_SOURCE;
				end else begin
					phase_d = opfp_pkg::PH_IDLE;
				end
			end
			opfp_pkg::PH_SOURCE: begin
				wr_en   = 1'b1;
				wr_pos  = opfp_pkg::POS_DEST;
				sum_d   = sum_q + rx_byte;
				phase_d = opfp_pkg::PH_DEST;
			end
			opfp_pkg::PH_DEST: begin
				wr_en   = 1'b1;
				wr_pos  = opfp_pkg::POS_FUNC;
				sum_d   = sum_q + rx_byte;
				phase_d = opfp_pkg::PH_FUNC;
			end
			opfp_pkg::PH_FUNC: begin
				wr_en           = 1'b1;
				wr_pos          = opfp_pkg::POS_LEN;
				sum_d           = sum_q + rx_byte;
				bytes_left_d    = rx_byte;
				payload_count_d = 8'd0;
				phase_d         = opfp_pkg::PH_PAYLOAD;
			end
			opfp_pkg::PH_PAYLOAD: begin
				if (bytes_left_q != 8'd0) begin
					wr_en           = 1'b1;
					wr_pos          = payload_pos;
					bytes_left_d    = bytes_left_q - 8'd1;
					payload_count_d = payload_count_q + 8'd1;
					sum_d           = sum_q + rx_byte;
					if (bytes_left_q == 8'd1) begin
						phase_d = opfp_pkg::PH_CSUM;
					end
				end else begin
					phase_d = opfp_pkg::PH_IDLE;
				end
			end
			opfp_pkg::PH_CSUM: begin
				wr_en   = 1'b1;
				wr_pos  = payload_pos;
				csum_ok = (sum_q == rx_byte);
				phase_d = opfp_pkg::PH_IDLE;
			end
			default: begin
				phase_d = opfp_pkg::PH_IDLE;
			end
		endcase
	end

	// store contents as seen after this byte's write
	always_comb begin
		for (int i = 0; i < opfp_pkg::STORE_DEPTH; i++) begin
			view[i] = (wr_en && wr_pos == opfp_pkg::POS_W'(i)) ? rx_byte : store_q[i];
		end
	end

	assign is_flow = csum_ok && view[3] == opfp_pkg::FUNC_FLOW && view[5] == opfp_pkg::MODE_FLOW;
	assign is_alt  = csum_ok && view[3] == opfp_pkg::FUNC_ALT && view[5] == opfp_pkg::MODE_ALT;
	assign push    = in_fire && (is_flow || is_alt);

	always_comb begin
		result_d = held_q;
		result_d.kind = is_alt ? opfp_pkg::KIND_ALT : opfp_pkg::KIND_FLOW;
		if (is_flow) begin
			result_d.quality       = view[6];
			result_d.speed_x       = {view[7], view[8]};
			result_d.speed_y       = {view[9], view[10]};
			result_d.speed_x_fixed = {view[11], view[12]};
			result_d.speed_y_fixed = {view[13], view[14]};
			result_d.dist_x        = {view[15], view[16]};
			result_d.dist_y        = {view[17], view[18]};
			result_d.light         = view[19];
		end
		if (is_alt) begin
			result_d.altitude = {view[6], view[7]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= opfp_pkg::PH_IDLE;
			source_q        <= opfp_pkg::SOURCE_RESET;
			bytes_left_q    <= 8'd0;
			payload_count_q <= 8'd0;
			sum_q           <= 8'd0;
			held_q          <= '0;
			for (int i = 0; i < opfp_pkg::STORE_DEPTH; i++) begin
				store_q[i] <= 8'd0;
			end
		end else begin
			if (cfg_we) begin
				source_q <= cfg_wdata;
			end
			if (in_fire) begin
				phase_q         <= phase_d;
				bytes_left_q    <= bytes_left_d;
				payload_count_q <= payload_count_d;
				sum_q           <= sum_d;
				for (int i = 0; i < opfp_pkg::STORE_DEPTH; i++) begin
					if (wr_en && wr_pos == opfp_pkg::POS_W'(i)) begin
						store_q[i] <= rx_byte;
					end
				end
			end
			if (push) begin
				held_q <= result_d;
			end
		end
	end

	// two-word result queue
	assign out_valid = (count_q != 2'd0);
	assign pop       = out_valid && out_ready;
	assign in_ready  = (count_q != 2'd2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= result_d;
		end
	end

	assign update_kind   = slot_q[rd_ptr_q].kind;
	assign quality       = slot_q[rd_ptr_q].quality;
	assign speed_x       = slot_q[rd_ptr_q].speed_x;
	assign speed_y       = slot_q[rd_ptr_q].speed_y;
	assign speed_x_fixed = slot_q[rd_ptr_q].speed_x_fixed;
	assign speed_y_fixed = slot_q[rd_ptr_q].speed_y_fixed;
	assign dist_x        = slot_q[rd_ptr_q].dist_x;
	assign dist_y        = slot_q[rd_ptr_q].dist_y;
	assign light         = slot_q[rd_ptr_q].light;
	assign altitude      = slot_q[rd_ptr_q].altitude;

	a_push_only_on_csum: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> phase_q == opfp_pkg::PH_CSUM)
		else $error("result pushed outside checksum phase");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q != 2'd3)
		else $error("result queue overflow");

	a_last_payload: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == opfp_pkg::PH_PAYLOAD && bytes_left_q == 8'd1
		|=> phase_q == opfp_pkg::PH_CSUM)
		else $error("last payload word did not lead to checksum");

	a_idle_hunt: assert property (@(posedge clk) disable iff (!arst_n)
		in_fire && phase_q == opfp_pkg::PH_IDLE && rx_byte != opfp_pkg::HEADER_BYTE
		|=> phase_q == opfp_pkg::PH_IDLE)
		else $error("left idle without header word");

	a_held_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!push |=> $stable(held_q))
		else $error("held values changed without a result");

endmodule

FILE: tb/opfp_checker.sv
// Checker for optical_flow_frame_parser: follows the parser on the input words,
// predicts each update word and compares accepted results field by field.
// Depends on opfp_pkg.
`timescale 1ns / 1ps
module opfp_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,
	input  logic               in_valid,
	input  logic               in_ready,
	input  logic [7:0]         rx_byte,
	input  logic               out_valid,
	input  logic               out_ready,
	input  logic               update_kind,
	input  logic [7:0]         quality,
	input  logic signed [15:0] speed_x,
	input  logic signed [15:0] speed_y,
	input  logic signed [15:0] speed_x_fixed,
	input  logic signed [15:0] speed_y_fixed,
	input  logic signed [15:0] dist_x,
	input  logic signed [15:0] dist_y,
	input  logic [7:0]         light,
	input  logic [15:0]        altitude,
	output int                 errors,
	output int                 pending
);

	localparam int FRAME_BYTES = 32;
	localparam int AT_QUALITY  = 6;
	localparam int AT_SPEED    = 7;
	localparam int AT_DIST     = 15;
	localparam int AT_LIGHT    = 19;
	localparam int AT_ALT      = 6;

	opfp_pkg::phase_t  phase;
	logic [7:0]        left_n;
	logic [7:0]        count;
	logic [7:0]        sum;
	logic [7:0]        source;
	logic [7:0]        store [FRAME_BYTES];
	logic [7:0]        h_quality;
	logic [15:0]       h_speed [4];
	logic [15:0]       h_dist [2];
	logic [7:0]        h_light;
	logic [15:0]       h_alt;
	opfp_pkg::result_t updates_due[$];

	initial errors = 0;

	task automatic report(input string msg);
		$display("%0t opfp_checker: %s", $time, msg);
		errors++;
	endtask

	task automatic keep_byte(input int pos, input logic [7:0] b);
		if (pos < FRAME_BYTES)
			store[pos] = b;
	endtask

	function automatic logic [15:0] word_at(input int pos);
		return {store[pos], store[pos + 1]};
	endfunction

	task automatic parse_byte(input logic [7:0] b);
		opfp_pkg::result_t upd;
		bit                hit;
		hit = 1'b0;
		case (phase)
		opfp_pkg::PH_IDLE: begin
			if (b == opfp_pkg::HEADER_BYTE) begin
				keep_byte(opfp_pkg::POS_HEADER, b);
				sum = b;
				phase = opfp_pkg::PH_HEADER;
			end
		end
		opfp_pkg::PH_HEADER: begin
			if (b == source) begin
				keep_byte(opfp_pkg::POS_SOURCE, b);
				sum += b;
				phase = opfp_pkg::PH_SOURCE;
			end else begin
				phase = opfp_pkg::PH_IDLE;
			end
		end
		opfp_pkg::PH_SOURCE, opfp_pkg::PH_DEST: begin
			keep_byte(int'(phase), b);
			sum += b;
			phase = opfp_pkg::phase_t'(phase + 3'd1);
		end
		opfp_pkg::PH_FUNC: begin
			keep_byte(opfp_pkg::POS_LEN, b);
			sum += b;
			left_n = b;
			count = 8'd0;
			phase = opfp_pkg::PH_PAYLOAD;
		end
		opfp_pkg::PH_PAYLOAD: begin
			if (left_n != 8'd0) begin
				left_n--;
				keep_byte(int'(opfp_pkg::POS_PAYLOAD) + count, b);
				count++;
				sum += b;
				if (left_n == 8'd0)
					phase = opfp_pkg::PH_CSUM;
			end else begin
				phase = opfp_pkg::PH_IDLE;
			end
		end
		opfp_pkg::PH_CSUM: begin
			phase = opfp_pkg::PH_IDLE;
			keep_byte(int'(opfp_pkg::POS_PAYLOAD) + count, b);
			if (sum == b) begin
				if (store[opfp_pkg::POS_FUNC] == opfp_pkg::FUNC_FLOW
						&& store[opfp_pkg::POS_PAYLOAD] == opfp_pkg::MODE_FLOW) begin
					h_quality = store[AT_QUALITY];
					for (int k = 0; k < 4; k++)
						h_speed[k] = word_at(AT_SPEED + 2 * k);
					h_dist[0] = word_at(AT_DIST);
					h_dist[1] = word_at(AT_DIST + 2);
					h_light = store[AT_LIGHT];
					upd.kind = opfp_pkg::KIND_FLOW;
					hit = 1'b1;
				end else if (store[opfp_pkg::POS_FUNC] == opfp_pkg::FUNC_ALT
						&& store[opfp_pkg::POS_PAYLOAD] == opfp_pkg::MODE_ALT) begin
					h_alt = word_at(AT_ALT);
					upd.kind = opfp_pkg::KIND_ALT;
					hit = 1'b1;
				end
			end
		end
		default: phase = opfp_pkg::PH_IDLE;
		endcase
		if (hit) begin
			upd.quality       = h_quality;
			upd.speed_x       = h_speed[0];
			upd.speed_y       = h_speed[1];
			upd.speed_x_fixed = h_speed[2];
			upd.speed_y_fixed = h_speed[3];
			upd.dist_x        = h_dist[0];
			upd.dist_y        = h_dist[1];
			upd.light         = h_light;
			upd.altitude      = h_alt;
			updates_due.push_back(upd);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		opfp_pkg::result_t want;
		if (!arst_n) begin
			phase = opfp_pkg::PH_IDLE;
			left_n = 8'd0;
			count = 8'd0;
			sum = 8'd0;
			source = opfp_pkg::SOURCE_RESET;
			foreach (store[i])
				store[i] = 8'd0;
			h_quality = 8'd0;
			foreach (h_speed[i])
				h_speed[i] = 16'd0;
			foreach (h_dist[i])
				h_dist[i] = 16'd0;
			h_light = 8'd0;
			h_alt = 16'd0;
			updates_due.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (updates_due.size() == 0) begin
					report("update word with none expected");
				end else begin
					want = updates_due.pop_front();
					if (update_kind !== want.kind)
						report($sformatf("update_kind got %h want %h", update_kind, want.kind));
					if (quality !== want.quality)
						report($sformatf("quality got %h want %h", quality, want.quality));
					if (speed_x !== want.speed_x)
						report($sformatf("speed_x got %h want %h", speed_x, want.speed_x));
					if (speed_y !== want.speed_y)
						report($sformatf("speed_y got %h want %h", speed_y, want.speed_y));
					if (speed_x_fixed !== want.speed_x_fixed)
						report($sformatf("speed_x_fixed got %h want %h",
							speed_x_fixed, want.speed_x_fixed));
					if (speed_y_fixed !== want.speed_y_fixed)
						report($sformatf("speed_y_fixed got %h want %h",
							speed_y_fixed, want.speed_y_fixed));
					if (dist_x !== want.dist_x)
						report($sformatf("dist_x got %h want %h", dist_x, want.dist_x));
					if (dist_y !== want.dist_y)
						report($sformatf("dist_y got %h want %h", dist_y, want.dist_y));
					if (light !== want.light)
						report($sformatf("light got %h want %h", light, want.light));
					if (altitude !== want.altitude)
						report($sformatf("altitude got %h want %h", altitude, want.altitude));
				end
			end
			if (in_valid && in_ready)
				parse_byte(rx_byte);
			if (cfg_we)
				source = cfg_wdata;
			pending = updates_due.size();
		end
	end

endmodule

FILE: tb/tb.sv
// Top of the frame parser testbench: clock, reset, byte stimulus with random
// idling on both channels, source register writes, watchdog and verdict.
// Depends on opfp_pkg, optical_flow_frame_parser and opfp_checker.
`timescale 1ns / 1ps
module tb;

	localparam int ITEMS      = 1650;
	localparam int PHASE_LEN  = 300;
	localparam int CALM_TAIL  = 200;
	localparam int IDLE_LIMIT = 2000;

	logic               clk = 1'b0;
	logic               arst_n;
	logic               cfg_we;
	logic [7:0]         cfg_wdata;
	logic               in_valid;
	logic               in_ready;
	logic [7:0]         rx_byte;
	logic               out_valid;
	logic               out_ready;
	logic               update_kind;
	logic [7:0]         quality;
	logic signed [15:0] speed_x;
	logic signed [15:0] speed_y;
	logic signed [15:0] speed_x_fixed;
	logic signed [15:0] speed_y_fixed;
	logic signed [15:0] dist_x;
	logic signed [15:0] dist_y;
	logic [7:0]         light;
	logic [15:0]        altitude;

	int         errors;
	int         pending;
	bit         quiet;
	bit         gaps_on;
	int         stall_left  = 0;
	int         idle_cycles = 0;
	int         sent;
	int         phase_no;
	int         roll;
	int         len_roll;
	int         len;
	logic [7:0] source_now;
	logic [7:0] fn;
	logic [7:0] b;
	logic [7:0] pay[$];

	optical_flow_frame_parser DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.update_kind   (update_kind),
		.quality       (quality),
		.speed_x       (speed_x),
		.speed_y       (speed_y),
		.speed_x_fixed (speed_x_fixed),
		.speed_y_fixed (speed_y_fixed),
		.dist_x        (dist_x),
		.dist_y        (dist_y),
		.light         (light),
		.altitude      (altitude)
	);

	opfp_checker update_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.update_kind   (update_kind),
		.quality       (quality),
		.speed_x       (speed_x),
		.speed_y       (speed_y),
		.speed_x_fixed (speed_x_fixed),
		.speed_y_fixed (speed_y_fixed),
		.dist_x        (dist_x),
		.dist_y        (dist_y),
		.light         (light),
		.altitude      (altitude),
		.errors        (errors),
		.pending       (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (!quiet && gaps_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles == IDLE_LIMIT) begin
			$display("tb: errors");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(0, 7))
		0: return 8'h00;
		1: return 8'hFF;
		2: return 8'h80;
		3: return 8'h7F;
		default: return 8'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] v);
		int gap;
		if (!quiet && gaps_on && $urandom_range(0, 6) == 0) begin
			gap = $urandom_range(1, 13);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte <= v;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic make_payload(input logic [7:0] mode, input int n);
		pay.delete();
		for (int i = 0; i < n; i++)
			pay.push_back(i == 0 ? mode : pick_byte());
	endtask

	// cut < 0 sends the whole frame, otherwise only its first cut words
	task automatic send_frame(input logic [7:0] dst, input logic [7:0] func,
			input bit bad_sum, input int cut);
		logic [7:0] words[$];
		logic [7:0] sum;
		int         stop;
		words.push_back(opfp_pkg::HEADER_BYTE);
		words.push_back(source_now);
		words.push_back(dst);
		words.push_back(func);
		words.push_back(8'(pay.size()));
		foreach (pay[i])
			words.push_back(pay[i]);
		sum = 8'd0;
		foreach (words[i])
			sum += words[i];
		words.push_back(bad_sum ? sum ^ 8'($urandom_range(1, 255)) : sum);
		stop = (cut < 0) ? words.size() : cut;
		foreach (words[i])
			if (i < stop) begin
				send_byte(words[i]);
				sent++;
			end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_source(input logic [7:0] v);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		source_now = v;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'd0;
		in_valid = 1'b0;
		rx_byte = 8'd0;
		out_ready = 1'b0;
		quiet = 1'b0;
		gaps_on = 1'b1;
		source_now = opfp_pkg::SOURCE_RESET;
		sent = 0;
		phase_no = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: idle noise, a broken source, altitude, zero length,
		// short flow frame, bad checksum
		send_byte(8'h00);
		send_byte(opfp_pkg::HEADER_BYTE);
		send_byte(opfp_pkg::HEADER_BYTE);
		pay = {opfp_pkg::MODE_ALT, 8'hFF, 8'h00};
		send_frame(8'hFF, opfp_pkg::FUNC_ALT, 1'b0, -1);
		pay.delete();
		send_frame(8'h00, opfp_pkg::FUNC_FLOW, 1'b0, 5);
		send_byte(opfp_pkg::HEADER_BYTE);
		pay = {opfp_pkg::MODE_FLOW};
		send_frame(8'h80, opfp_pkg::FUNC_FLOW, 1'b0, -1);
		pay = {opfp_pkg::MODE_ALT};
		send_frame(8'h7F, opfp_pkg::FUNC_ALT, 1'b1, -1);

		while (sent < ITEMS) begin
			if (sent / PHASE_LEN != phase_no) begin
				phase_no = sent / PHASE_LEN;
				drain();
				case (phase_no)
				1: write_source(8'hFF);
				2: write_source(8'h00);
				3: write_source(8'($urandom));
				4: write_source(opfp_pkg::HEADER_BYTE);
				default: write_source(opfp_pkg::SOURCE_RESET);
				endcase
				gaps_on = (phase_no % 3) != 2;
			end
			quiet = sent >= ITEMS - CALM_TAIL;
			roll = $urandom_range(0, 99);
			if (roll < 38) begin
				len_roll = $urandom_range(0, 49);
				if (len_roll == 0)
					len = $urandom_range(200, 255);
				else if (len_roll < 3)
					len = $urandom_range(27, 60);
				else if (len_roll < 12)
					len = $urandom_range(1, 26);
				else
					len = 15;
				make_payload(opfp_pkg::MODE_FLOW, len);
				send_frame(pick_byte(), opfp_pkg::FUNC_FLOW, 1'b0, -1);
			end else if (roll < 63) begin
				len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : 3;
				make_payload(opfp_pkg::MODE_ALT, len);
				send_frame(pick_byte(), opfp_pkg::FUNC_ALT, 1'b0, -1);
			end else if (roll < 71) begin
				case ($urandom_range(0, 2))
				0: fn = opfp_pkg::FUNC_FLOW;
				1: fn = opfp_pkg::FUNC_ALT;
				default: fn = pick_byte();
				endcase
				make_payload(pick_byte(), $urandom_range(1, 16));
				send_frame(pick_byte(), fn, 1'b0, -1);
			end else if (roll < 79) begin
				if ($urandom_range(0, 1)) begin
					make_payload(opfp_pkg::MODE_ALT, 3);
					send_frame(pick_byte(), opfp_pkg::FUNC_ALT, 1'b1, -1);
				end else begin
					make_payload(opfp_pkg::MODE_FLOW, 15);
					send_frame(pick_byte(), opfp_pkg::FUNC_FLOW, 1'b1, -1);
				end
			end else if (roll < 84) begin
				pay.delete();
				send_frame(pick_byte(),
					$urandom_range(0, 1) ? opfp_pkg::FUNC_FLOW : opfp_pkg::FUNC_ALT,
					1'b0, -1);
			end else if (roll < 90) begin
				b = pick_byte();
				if (b == source_now)
					b = b + 8'd1;
				send_byte(opfp_pkg::HEADER_BYTE);
				send_byte(b);
				sent += 2;
			end else if (roll < 95) begin
				make_payload(opfp_pkg::MODE_FLOW, 15);
				send_frame(pick_byte(), opfp_pkg::FUNC_FLOW, 1'b0, $urandom_range(1, 20));
			end else begin
				repeat ($urandom_range(1, 4)) begin
					send_byte(pick_byte());
					sent++;
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("tb: clean");
		else
			$display("tb: errors");
		$finish;
	end

endmodule
